### sv/nrt_pkg.sv
// Shared types, constants and helper functions for the nonce replay table.
`timescale 1ns / 1ps

package nrt_pkg;

  localparam int NONCE_W = 64;
  localparam int TIME_W  = 40;
  localparam int EXP_W   = 41;
  localparam int TTL_W   = 32;
  localparam int ST_W    = 2;
  localparam int LIVE_W  = 7;

  localparam int              MAX_ENTRIES_DEF = 64;
  localparam int              NONCE_BYTES_DEF = 16;
  localparam logic [TTL_W-1:0] DEFAULT_TTL_DEF = 32'd300;

  // Request operation codes.
  localparam logic OP_SPEND = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_STORED  = 2'd0;
  localparam logic [ST_W-1:0] ST_REPLAY  = 2'd1;
  localparam logic [ST_W-1:0] ST_CLEARED = 2'd2;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic               valid;
    logic [EXP_W-1:0]   expiry;
    logic [NONCE_W-1:0] hi;
    logic [NONCE_W-1:0] lo;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            idx_clr;
    logic            idx_inc;
    logic            clr_wr;
    logic            rd;
    logic            sweep;
    logic            acc_clr;
    logic            store;
    logic            resp;
    logic [ST_W-1:0] resp_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic hit;
  } sts_t;

  // Mask that keeps the low nbytes bytes of a 64-bit word.
  function automatic logic [NONCE_W-1:0] byte_mask(input int nbytes);
    logic [NONCE_W-1:0] m;
    m = '0;
    for (int b = 0; b < NONCE_W / 8; b++) begin
      if (b < nbytes) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

### sv/nonce_replay_table_top.sv
// Top level of the nonce replay table: controller, datapath and port checks.
// A check request that is not a replay reports after a lookup pass, a sweep pass and a store,
// a replay reports after the lookup pass and a clear after one clearing pass over every entry.
// One request at a time; busy stays high until the result strobe, while the single-port entry
// memory makes full passes over every entry.
// Reset: a clearing pass writes every entry invalid, with busy high.
// The result is shown for one cycle on done; the receiver cannot stall it.
`timescale 1ns / 1ps

module nonce_replay_table_top #(
  parameter int                        MAX_ENTRIES         = nrt_pkg::MAX_ENTRIES_DEF,
  parameter int                        NONCE_BYTES         = nrt_pkg::NONCE_BYTES_DEF,
  parameter logic [nrt_pkg::TTL_W-1:0] DEFAULT_TTL_SECONDS = nrt_pkg::DEFAULT_TTL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [nrt_pkg::NONCE_W-1:0] nonce_low,
  input  logic [nrt_pkg::NONCE_W-1:0] nonce_high,
  input  logic [nrt_pkg::TIME_W-1:0]  current_time,
  input  logic                        ttl_write,
  input  logic [nrt_pkg::TTL_W-1:0]   ttl_seconds,
  output logic                        done,
  output logic [nrt_pkg::ST_W-1:0]    status,
  output logic [nrt_pkg::LIVE_W-1:0]  live_count
);

  // The controller sequences the passes over the table; the datapath owns the
  // memory, the scan index, the accumulators of the lookup pass and the count.
  nrt_pkg::cmd_t cmd;
  nrt_pkg::sts_t sts;

  nrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // The lookup pass decides replay, the first free slot and the eviction victim;
  // only when the request is not a replay does a second pass sweep expired
  // entries, after which the new entry is written.
  nrt_datapath #(
    .MAX_ENTRIES         (MAX_ENTRIES),
    .NONCE_BYTES         (NONCE_BYTES),
    .DEFAULT_TTL_SECONDS (DEFAULT_TTL_SECONDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .nonce_low    (nonce_low),
    .nonce_high   (nonce_high),
    .current_time (current_time),
    .ttl_write    (ttl_write),
    .ttl_seconds  (ttl_seconds),
    .done         (done),
    .status       (status),
    .live_count   (live_count)
  );

  // A taken request always keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // A result only follows a cycle in which a request was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  // A cleared table reports no live entries.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == nrt_pkg::ST_CLEARED)) |-> (live_count == '0))
    else $error("clear result with nonzero live count");

  // The memory is never written by a clearing pass and a store in the same cycle.
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (!cmd.clr_wr && $past(!cmd.rd)))
    else $error("store overlaps another table access");

endmodule

### sv/nrt_datapath.sv
// Datapath of the nonce replay table: entry memory, scan accumulators, count and result.
`timescale 1ns / 1ps

module nrt_datapath #(
  parameter int                        MAX_ENTRIES         = nrt_pkg::MAX_ENTRIES_DEF,
  parameter int                        NONCE_BYTES         = nrt_pkg::NONCE_BYTES_DEF,
  parameter logic [nrt_pkg::TTL_W-1:0] DEFAULT_TTL_SECONDS = nrt_pkg::DEFAULT_TTL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nrt_pkg::cmd_t                 cmd,
  output nrt_pkg::sts_t                 sts,
  input  logic [nrt_pkg::NONCE_W-1:0]   nonce_low,
  input  logic [nrt_pkg::NONCE_W-1:0]   nonce_high,
  input  logic [nrt_pkg::TIME_W-1:0]    current_time,
  input  logic                          ttl_write,
  input  logic [nrt_pkg::TTL_W-1:0]     ttl_seconds,
  output logic                          done,
  output logic [nrt_pkg::ST_W-1:0]      status,
  output logic [nrt_pkg::LIVE_W-1:0]    live_count
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [nrt_pkg::NONCE_W-1:0] LO_MASK = nrt_pkg::byte_mask(NONCE_BYTES);
  localparam logic [nrt_pkg::NONCE_W-1:0] HI_MASK = nrt_pkg::byte_mask(NONCE_BYTES - 8);

  nrt_pkg::entry_t mem [MAX_ENTRIES];
  nrt_pkg::entry_t rd_data;

  logic [nrt_pkg::TTL_W-1:0]   ttl;
  logic [nrt_pkg::TTL_W-1:0]   ttl_eff;
  logic [nrt_pkg::NONCE_W-1:0] lo_q;
  logic [nrt_pkg::NONCE_W-1:0] hi_q;
  logic [nrt_pkg::TIME_W-1:0]  now_q;
  logic [nrt_pkg::EXP_W-1:0]   exp_new;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic             rd_sweep;

  logic                      hit;
  logic                      have_free;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          min_idx;
  logic [nrt_pkg::EXP_W-1:0] min_exp;
  logic [CNT_W-1:0]          n_exp;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_new;
  logic [CNT_W+nrt_pkg::LIVE_W-1:0] live_ext;

  logic e_expired;
  logic e_live;
  logic e_match;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  nrt_pkg::entry_t      wr_data;
  logic [IDX_W-1:0]     slot;

  assign ttl_eff = (ttl == '0) ? DEFAULT_TTL_SECONDS : ttl;

  assign e_expired = rd_data.valid && ({1'b0, now_q} >= rd_data.expiry);
  assign e_live    = rd_data.valid && !e_expired;
  assign e_match   = e_live && (rd_data.lo == lo_q) && (rd_data.hi == hi_q);

  assign slot      = have_free ? free_idx : min_idx;
  assign count_new = count - n_exp + CNT_W'(have_free);

  assign sts.idx_last = (idx == IDX_W'(MAX_ENTRIES - 1));
  assign sts.hit      = hit;

  // Write port: clearing pass, sweep write-back and the final store never overlap.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '0;
    priority if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (rd_vld && rd_sweep && e_expired) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx;
    end else if (cmd.store) begin
      wr_en          = 1'b1;
      wr_addr        = slot;
      wr_data.valid  = 1'b1;
      wr_data.expiry = exp_new;
      wr_data.hi     = hi_q;
      wr_data.lo     = lo_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data <= mem[idx];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= '0;
    end else if (ttl_write) begin
      ttl <= ttl_seconds;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_q    <= nonce_low & LO_MASK;
      hi_q    <= nonce_high & HI_MASK;
      now_q   <= current_time;
      exp_new <= {1'b0, current_time} + {{(nrt_pkg::EXP_W - nrt_pkg::TTL_W){1'b0}}, ttl_eff};
    end
  end

  // Scan index and read pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_vld   <= 1'b0;
      rd_sweep <= 1'b0;
    end else begin
      rd_vld   <= cmd.rd;
      rd_sweep <= cmd.sweep;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= sts.idx_last ? '0 : idx + IDX_W'(1);
      end
    end
    rd_idx <= idx;
  end

  // Lookup pass accumulators: replay hit, expired count, first free slot, soonest expiry.
  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clr) begin
      hit       <= 1'b0;
      have_free <= 1'b0;
      n_exp     <= '0;
    end else if (rd_vld && !rd_sweep) begin
      hit   <= hit | e_match;
      n_exp <= n_exp + CNT_W'(e_expired);
      if (!e_live && !have_free) have_free <= 1'b1;
    end
    if (rd_vld && !rd_sweep) begin
      if (!e_live && !have_free) free_idx <= rd_idx;
      if ((rd_idx == '0) || (rd_data.expiry < min_exp)) begin
        min_exp <= rd_data.expiry;
        min_idx <= rd_idx;
      end
    end
  end

  // Occupied count.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_wr) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= count_new;
    end
  end

  // Result register.
  always_comb begin
    unique case (cmd.resp_code)
      nrt_pkg::ST_STORED: live_ext = {{nrt_pkg::LIVE_W{1'b0}}, count_new};
      nrt_pkg::ST_REPLAY: live_ext = {{nrt_pkg::LIVE_W{1'b0}}, count};
      default:            live_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp;
    end
    if (cmd.resp) begin
      status     <= cmd.resp_code;
      live_count <= live_ext[nrt_pkg::LIVE_W-1:0];
    end
  end

endmodule

### sv/nrt_ctrl.sv
// Controller state machine of the nonce replay table.
`timescale 1ns / 1ps

module nrt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          operation,
  input  nrt_pkg::sts_t sts,
  output nrt_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_CLEAR     = 4'd2;
  localparam logic [3:0] S_LOOK      = 4'd3;
  localparam logic [3:0] S_LOOK_END  = 4'd4;
  localparam logic [3:0] S_DECIDE    = 4'd5;
  localparam logic [3:0] S_SWEEP     = 4'd6;
  localparam logic [3:0] S_SWEEP_END = 4'd7;
  localparam logic [3:0] S_STORE     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          cmd.acc_clr = 1'b1;
          state_next  = (operation == nrt_pkg::OP_CLEAR) ? S_CLEAR : S_LOOK;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          cmd.resp      = 1'b1;
          cmd.resp_code = nrt_pkg::ST_CLEARED;
          state_next    = S_IDLE;
        end
      end
      S_LOOK: begin
        cmd.rd      = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) state_next = S_LOOK_END;
      end
      S_LOOK_END: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.hit) begin
          cmd.resp      = 1'b1;
          cmd.resp_code = nrt_pkg::ST_REPLAY;
          state_next    = S_IDLE;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.rd      = 1'b1;
        cmd.sweep   = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) state_next = S_SWEEP_END;
      end
      S_SWEEP_END: begin
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store     = 1'b1;
        cmd.resp      = 1'b1;
        cmd.resp_code = nrt_pkg::ST_STORED;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
